>>> design/aarm_pkg.sv
// Package for the axis-angle rotation matrix block: widths, constants, tables.
package aarm_pkg;

  localparam int CordicStages = 16;
  localparam int AtanEntries  = 24;
  localparam int NumStages    = (CordicStages < AtanEntries) ? CordicStages : AtanEntries;

  localparam int CW = 24;   // CORDIC x/y/z width, Q.20 / Q.16 degrees

  localparam logic signed [CW-1:0] CordicGain = 24'sd636750;
  localparam logic signed [16:0]   TurnUnits  = 17'sd23040;
  localparam logic signed [16:0]   HalfTurn   = 17'sd11520;
  localparam logic signed [16:0]   QuarterTurn = 17'sd5760;
  localparam logic [34:0] LenLo = 35'd67102153;
  localparam logic [34:0] LenHi = 35'd67115575;
  localparam logic signed [47:0] OneQ20 = 48'sd1048576;

  function automatic logic signed [CW-1:0] atan_q16(input int i);
    logic signed [CW-1:0] t [AtanEntries];
    t = '{24'sd2949120, 24'sd1740967, 24'sd919879, 24'sd466945, 24'sd234379,
          24'sd117305, 24'sd58666, 24'sd29335, 24'sd14668, 24'sd7334, 24'sd3667,
          24'sd1833, 24'sd917, 24'sd458, 24'sd229, 24'sd115, 24'sd57, 24'sd29,
          24'sd14, 24'sd7, 24'sd4, 24'sd2, 24'sd1, 24'sd0};
    return t[i];
  endfunction

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } cordic_t;

  // Axis side-band carried down the chain: fold flag, normalise flag, raw axis.
  typedef struct packed {
    logic                 flip;
    logic                 norm;
    logic signed [15:0]   ax;
    logic signed [15:0]   ay;
    logic signed [15:0]   az;
  } axis_t;

endpackage

>>> design/aarm_cell.sv
// One CORDIC rotation cell: a single micro-rotation of the sine/cosine chain.
module aarm_cell (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [4:0]         idx_i,
  input  aarm_pkg::cordic_t  c_i,
  output aarm_pkg::cordic_t  c_o
);
  import aarm_pkg::*;

  cordic_t c_d, c_q;
  logic signed [CW-1:0] dx, dy, atan_v;

  always_comb begin
    dx     = c_i.y >>> idx_i;
    dy     = c_i.x >>> idx_i;
    atan_v = atan_q16(int'(idx_i));
    if (!c_i.z[CW-1]) begin
      c_d.x = c_i.x - dx;
      c_d.y = c_i.y + dy;
      c_d.z = c_i.z - atan_v;
    end else begin
      c_d.x = c_i.x + dx;
      c_d.y = c_i.y - dy;
      c_d.z = c_i.z + atan_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_q <= c_d;
    end
  end

  assign c_o = c_q;
endmodule

>>> design/aarm_sqrt.sv
// Pipelined square root of the scaled squared length, one root bit per stage.
module aarm_sqrt (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [34:0] len_i,
  output logic [30:0] root_o
);

  localparam int RB = 31;
  logic [61:0] rad  [RB+1];
  logic [32:0] rem  [RB+1];
  logic [30:0] root [RB+1];

  // radicand is the squared length scaled by 2^26
  assign rad[0]  = {1'b0, len_i, 26'd0};
  assign rem[0]  = '0;
  assign root[0] = '0;

  for (genvar g = 0; g < RB; g++) begin : g_bit
    logic [32:0] rem_d, trial;
    logic [30:0] root_d;
    logic [61:0] rad_d;
    logic [32:0] rem_q;
    logic [30:0] root_q;
    logic [61:0] rad_q;
    always_comb begin
      rem_d = {rem[g][30:0], rad[g][61:60]};
      trial = {root[g], 2'b01};
      if (rem_d >= trial) begin
        rem_d  = rem_d - trial;
        root_d = {root[g][29:0], 1'b1};
      end else begin
        root_d = {root[g][29:0], 1'b0};
      end
      rad_d = {rad[g][59:0], 2'b00};
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q  <= rem_d;
        root_q <= root_d;
        rad_q  <= rad_d;
      end
    end
    assign rem[g+1]  = rem_q;
    assign root[g+1] = root_q;
    assign rad[g+1]  = rad_q;
  end

  assign root_o = root[RB];
endmodule

>>> design/axis_angle_rotation_matrix_top.sv
// Top level: axis-angle to 3x3 rotation matrix, fully pipelined.
//
// Usage:
//   s_axis carries one request per beat: tdata = {axis_z, axis_y, axis_x,
//   angle_deg}, lowest bits first. m_axis returns the nine matrix entries,
//   Q1.14 saturated, row-major from the lowest bits of tdata.
//   One request is accepted every cycle while the output is not stalled.
//   A request passes through the square root chain, the per-component
//   divide, the products and the output register; the CORDIC cells ride
//   alongside the root chain.
//   The whole pipeline advances only when the output register is empty or
//   being taken, so a stalled receiver freezes every stage and holds
//   s_axis_tready low until the output beat leaves.
//   Reset clears all valid bits; data registers are not reset.
module axis_angle_rotation_matrix_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [63:0]  s_axis_tdata,   // angle_deg, axis_x, axis_y, axis_z
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [143:0] m_axis_tdata    // row0_col0 .. row2_col2
);
  import aarm_pkg::*;

  localparam int SqLat  = 31;
  localparam int DivLat = 21;
  localparam int Lat    = SqLat + DivLat + 3;

  logic en;
  logic [Lat-2:0] vld_q;
  logic out_vld_q;
  assign en = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = out_vld_q;

  // ---- input decode, angle fold ----
  logic signed [15:0] ang, axx, axy, axz;
  logic signed [16:0] u;
  logic flip;
  logic [34:0] len;
  logic norm;
  assign ang = s_axis_tdata[15:0];
  assign axx = s_axis_tdata[31:16];
  assign axy = s_axis_tdata[47:32];
  assign axz = s_axis_tdata[63:48];

  always_comb begin
    u = 17'(ang);
    if (u >= HalfTurn) u = u - TurnUnits;
    else if (u < -HalfTurn) u = u + TurnUnits;
    flip = 1'b0;
    if (u > QuarterTurn) begin
      u = u - HalfTurn; flip = 1'b1;
    end else if (u < -QuarterTurn) begin
      u = u + HalfTurn; flip = 1'b1;
    end
    len = 35'(32'(axx * axx)) + 35'(32'(axy * axy)) + 35'(32'(axz * axz));
    norm = (len <= LenLo || len >= LenHi) && (len != '0);
  end

  // ---- CORDIC chain of cells ----
  cordic_t cc [NumStages+1];
  assign cc[0] = '{x: CordicGain, y: '0, z: CW'(u) <<< 10};
  for (genvar g = 0; g < NumStages; g++) begin : g_cordic
    aarm_cell u_cell (
      .clk_i(clk_i), .en_i(en), .idx_i(5'(g)), .c_i(cc[g]), .c_o(cc[g+1])
    );
  end

  // axis side-band delay to the root result
  axis_t sb [SqLat+1];
  assign sb[0] = '{flip: flip, norm: norm, ax: axx, ay: axy, az: axz};
  for (genvar g = 0; g < SqLat; g++) begin : g_sb
    axis_t sb_q;
    always_ff @(posedge clk_i) if (en) sb_q <= sb[g];
    assign sb[g+1] = sb_q;
  end

  // c, s delayed from CORDIC end to root end
  logic signed [CW-1:0] cd [SqLat-NumStages+1];
  logic signed [CW-1:0] sd [SqLat-NumStages+1];
  assign cd[0] = cc[NumStages].x;
  assign sd[0] = cc[NumStages].y;
  for (genvar g = 0; g < SqLat - NumStages; g++) begin : g_cs
    logic signed [CW-1:0] c_q, s_q;
    always_ff @(posedge clk_i) if (en) begin c_q <= cd[g]; s_q <= sd[g]; end
    assign cd[g+1] = c_q;
    assign sd[g+1] = s_q;
  end

  logic [30:0] root;
  aarm_sqrt u_sqrt (.clk_i(clk_i), .en_i(en), .len_i(len), .root_o(root));

  // ---- per-component restoring divide: q = |a|<<33 / root, 21 bits ----
  logic [15:0] mg [3];
  assign mg[0] = sb[SqLat].ax[15] ? 16'(-sb[SqLat].ax) : 16'(sb[SqLat].ax);
  assign mg[1] = sb[SqLat].ay[15] ? 16'(-sb[SqLat].ay) : 16'(sb[SqLat].ay);
  assign mg[2] = sb[SqLat].az[15] ? 16'(-sb[SqLat].az) : 16'(sb[SqLat].az);

  // Stage state: remainder and quotient per lane.
  logic [30:0] rm [DivLat+1][3];
  logic [20:0] qt [DivLat+1][3];
  logic [30:0] dr [DivLat+1];
  axis_t       sbd [DivLat+1];
  logic signed [CW-1:0] cdd [DivLat+1];
  logic signed [CW-1:0] sdd [DivLat+1];

  // quotient never exceeds 2^20, so the top 28 dividend bits start below root
  for (genvar l = 0; l < 3; l++) begin : g_lane
    assign rm[0][l] = {3'd0, mg[l], 12'd0};
    assign qt[0][l] = '0;
  end
  assign dr[0]  = root;
  assign sbd[0] = sb[SqLat];
  assign cdd[0] = cd[SqLat-NumStages];
  assign sdd[0] = sd[SqLat-NumStages];

  for (genvar g = 0; g < DivLat; g++) begin : g_div
    logic [31:0] t    [3];
    logic [30:0] rm_d [3];
    logic [20:0] qt_d [3];
    logic [30:0] rm_q [3];
    logic [20:0] qt_q [3];
    logic [30:0] dr_q;
    axis_t       sb_q;
    logic signed [CW-1:0] c_q, s_q;
    always_comb begin
      for (int l = 0; l < 3; l++) begin
        // low dividend bits are all zero
        t[l] = {rm[g][l], 1'b0};
        if (t[l] >= {1'b0, dr[g]}) begin
          rm_d[l] = 31'(t[l] - {1'b0, dr[g]});
          qt_d[l] = {qt[g][l][19:0], 1'b1};
        end else begin
          rm_d[l] = t[l][30:0];
          qt_d[l] = {qt[g][l][19:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk_i) if (en) begin
      rm_q <= rm_d; qt_q <= qt_d;
      dr_q <= dr[g]; sb_q <= sbd[g]; c_q <= cdd[g]; s_q <= sdd[g];
    end
    assign rm[g+1] = rm_q;
    assign qt[g+1] = qt_q;
    assign dr[g+1] = dr_q;
    assign sbd[g+1] = sb_q;
    assign cdd[g+1] = c_q;
    assign sdd[g+1] = s_q;
  end

  // ---- unit axis select, pair products ----
  logic signed [22:0] ux, uy, uz;
  logic signed [CW-1:0] cf, sf;
  always_comb begin
    axis_t a;
    a = sbd[DivLat];
    if (a.norm) begin
      ux = a.ax[15] ? -23'(qt[DivLat][0]) : 23'(qt[DivLat][0]);
      uy = a.ay[15] ? -23'(qt[DivLat][1]) : 23'(qt[DivLat][1]);
      uz = a.az[15] ? -23'(qt[DivLat][2]) : 23'(qt[DivLat][2]);
    end else begin
      ux = 23'(a.ax) <<< 7;
      uy = 23'(a.ay) <<< 7;
      uz = 23'(a.az) <<< 7;
    end
    cf = a.flip ? -cdd[DivLat] : cdd[DivLat];
    sf = a.flip ? -sdd[DivLat] : sdd[DivLat];
  end

  logic signed [45:0] pxx_q, pyy_q, pzz_q, pxy_q, pyz_q, pxz_q;
  logic signed [46:0] zs_q, ys_q, xs_q;
  logic signed [CW-1:0] c1_q;
  logic signed [CW:0]   omc1_q;
  always_ff @(posedge clk_i) if (en) begin
    pxx_q <= ux * ux; pyy_q <= uy * uy; pzz_q <= uz * uz;
    pxy_q <= ux * uy; pyz_q <= uy * uz; pxz_q <= ux * uz;
    zs_q  <= uz * sf; ys_q <= uy * sf; xs_q <= ux * sf;
    c1_q  <= cf;
    omc1_q <= (CW+1)'(OneQ20) - (CW+1)'(cf);
  end

  logic signed [25:0] f [6];
  always_comb begin
    f[0] = 26'(pxx_q >>> 20); f[1] = 26'(pyy_q >>> 20); f[2] = 26'(pzz_q >>> 20);
    f[3] = 26'(pxy_q >>> 20); f[4] = 26'(pyz_q >>> 20); f[5] = 26'(pxz_q >>> 20);
  end

  logic signed [51:0] m_q [6];
  logic signed [46:0] zs2_q, ys2_q, xs2_q;
  logic signed [47:0] cq_q;
  always_ff @(posedge clk_i) if (en) begin
    for (int k = 0; k < 6; k++) m_q[k] <= f[k] * omc1_q;
    zs2_q <= zs_q; ys2_q <= ys_q; xs2_q <= xs_q;
    cq_q  <= 48'(c1_q) <<< 20;
  end

  function automatic logic [15:0] q14(input logic signed [52:0] v);
    logic signed [52:0] r;
    r = (v + 53'sd33554432) >>> 26;
    if (r > 53'sd16384) return 16'd16384;
    if (r < -53'sd16384) return 16'(-16384);
    return r[15:0];
  endfunction

  logic [143:0] res;
  always_comb begin
    res[15:0]    = q14(53'(m_q[0]) + 53'(cq_q));
    res[31:16]   = q14(53'(m_q[3]) - 53'(zs2_q));
    res[47:32]   = q14(53'(m_q[5]) + 53'(ys2_q));
    res[63:48]   = q14(53'(m_q[3]) + 53'(zs2_q));
    res[79:64]   = q14(53'(m_q[1]) + 53'(cq_q));
    res[95:80]   = q14(53'(m_q[4]) - 53'(xs2_q));
    res[111:96]  = q14(53'(m_q[5]) - 53'(ys2_q));
    res[127:112] = q14(53'(m_q[4]) + 53'(xs2_q));
    res[143:128] = q14(53'(m_q[2]) + 53'(cq_q));
  end

  always_ff @(posedge clk_i) if (en) m_axis_tdata <= res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q     <= {vld_q[Lat-3:0], s_axis_tvalid};
      out_vld_q <= vld_q[Lat-2];
    end
  end

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed under stall");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready) else $error("ready low while output empty");
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && vld_q[Lat-2] |=> m_axis_tvalid) else $error("lost item");
endmodule

>>> test/axis_angle_rotation_matrix_top_tb.sv
// Testbench for the axis-angle rotation matrix block: predictor, scoreboard and stimulus.
`timescale 1ns / 1ps

module axis_angle_rotation_matrix_top_tb;
  import aarm_pkg::*;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [63:0]  s_axis_tdata;   // angle_deg, axis_x, axis_y, axis_z
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [143:0] m_axis_tdata;   // row0_col0 .. row2_col2

  int send_idle;
  int recv_idle;

  axis_angle_rotation_matrix_top DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  class matrix_scoreboard;
    logic [143:0] pending_matrices[$];
    int           fails;

    function new();
      fails = 0;
    endfunction

    static function longint unsigned root64(longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    static function longint unit_comp(longint a, longint unsigned len);
      longint unsigned mag;
      longint q;
      mag = (a < 0) ? -a : a;
      q = longint'((mag << 33) / len);
      return (a < 0) ? -q : q;
    endfunction

    static function logic [15:0] round_q14(longint v);
      longint r;
      r = (v + (64'sd1 << 25)) >>> 26;
      if (r > 16384) r = 16384;
      if (r < -16384) r = -16384;
      return r[15:0];
    endfunction

    static function logic [143:0] rotation_of(logic [63:0] req);
      longint atan_tab[24] = '{2949120, 1740967, 919879, 466945, 234379, 117305, 58666,
                               29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57,
                               29, 14, 7, 4, 2, 1, 0};
      longint ax, ay, az, l, x, y, z, c, s, omc, xx, yy, zz, xy, yz, xz;
      longint units, cx, cy, cz, dx, dy;
      longint unsigned len;
      bit flip;
      logic [143:0] m;
      units = longint'($signed(req[15:0]));
      ax = longint'($signed(req[31:16]));
      ay = longint'($signed(req[47:32]));
      az = longint'($signed(req[63:48]));
      l = ax * ax + ay * ay + az * az;
      if ((l <= 67102153 || l >= 67115575) && l != 0) begin
        len = root64(longint'(l) << 26);
        x = unit_comp(ax, len);
        y = unit_comp(ay, len);
        z = unit_comp(az, len);
      end else begin
        x = ax * 128;
        y = ay * 128;
        z = az * 128;
      end
      // wrap to one turn, then fold into the right half-plane
      while (units >= 11520) units -= 23040;
      while (units < -11520) units += 23040;
      flip = 0;
      if (units > 5760) begin
        units -= 11520;
        flip = 1;
      end else if (units < -5760) begin
        units += 11520;
        flip = 1;
      end
      cx = 636750;
      cy = 0;
      cz = units * 1024;
      for (int i = 0; i < NumStages; i++) begin
        dx = cy >>> i;
        dy = cx >>> i;
        if (cz >= 0) begin
          cx -= dx; cy += dy; cz -= atan_tab[i];
        end else begin
          cx += dx; cy -= dy; cz += atan_tab[i];
        end
      end
      c = flip ? -cx : cx;
      s = flip ? -cy : cy;
      omc = 1048576 - c;
      xx = (x * x) >>> 20;
      yy = (y * y) >>> 20;
      zz = (z * z) >>> 20;
      xy = (x * y) >>> 20;
      yz = (y * z) >>> 20;
      xz = (x * z) >>> 20;
      m[15:0]    = round_q14(xx * omc + c * 1048576);
      m[31:16]   = round_q14(xy * omc - z * s);
      m[47:32]   = round_q14(xz * omc + y * s);
      m[63:48]   = round_q14(xy * omc + z * s);
      m[79:64]   = round_q14(yy * omc + c * 1048576);
      m[95:80]   = round_q14(yz * omc - x * s);
      m[111:96]  = round_q14(xz * omc - y * s);
      m[127:112] = round_q14(yz * omc + x * s);
      m[143:128] = round_q14(zz * omc + c * 1048576);
      return m;
    endfunction

    function void note_request(logic [63:0] req);
      pending_matrices.push_back(rotation_of(req));
    endfunction

    task report_mismatch(string what, int idx, logic [15:0] got, logic [15:0] want);
      $display("MISMATCH %s entry %0d: got %0d expected %0d", what, idx,
               $signed(got), $signed(want));
      fails++;
    endtask

    task check_matrix(logic [143:0] got);
      logic [143:0] want;
      if (pending_matrices.size() == 0) begin
        report_mismatch("unexpected result", 0, got[15:0], 16'd0);
      end else begin
        want = pending_matrices.pop_front();
        for (int k = 0; k < 9; k++)
          if (got[16*k +: 16] !== want[16*k +: 16])
            report_mismatch("matrix", k, got[16*k +: 16], want[16*k +: 16]);
      end
    endtask
  endclass

  matrix_scoreboard sb;

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_request(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) sb.check_matrix(m_axis_tdata);
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  task send_request(logic signed [15:0] ang, logic signed [15:0] x,
                    logic signed [15:0] y, logic signed [15:0] z);
    while ($urandom_range(0, 99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {z, y, x, ang};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task send_random;
    int kind;
    logic signed [15:0] ang;
    kind = $urandom_range(0, 9);
    ang = 16'($signed($urandom_range(0, 46080)) - 23040);
    if (kind < 5)
      send_request(ang, 16'($urandom), 16'($urandom), 16'($urandom));
    else if (kind < 8)   // length at or just below the no-renormalise window
      send_request(ang, 16'(8192 - $urandom_range(0, 1)), 16'($urandom_range(0, 40) - 20),
                   16'($urandom_range(0, 40) - 20));
    else if (kind < 9)
      send_request(ang, 16'd0, 16'd0, 16'd0);
    else
      send_request(ang, 16'($urandom_range(0, 16384) - 8192), 16'($urandom_range(0, 32)),
                   16'($urandom_range(0, 16384) - 8192));
  endtask

  task wait_drained;
    s_axis_tvalid <= 1'b0;
    // let the monitor log the last accepted request first
    @(posedge clk_i);
    while (sb.pending_matrices.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    sb = new();
    s_axis_tvalid = 0;
    s_axis_tdata  = '0;
    m_axis_tready = 0;
    send_idle = 0;
    recv_idle = 0;
    rst_ni = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: angle extremes, fold points, unit axes, zero axis, axis extremes
    send_request(16'sd0, 16'sd8192, 16'sd0, 16'sd0);
    send_request(16'sd5760, 16'sd0, 16'sd0, 16'sd8192);
    send_request(-16'sd5760, 16'sd0, 16'sd8192, 16'sd0);
    send_request(16'sd5761, 16'sd8192, 16'sd8192, 16'sd0);
    send_request(-16'sd5761, 16'sd0, 16'sd8192, 16'sd8192);
    send_request(16'sd11519, 16'sd8192, 16'sd0, 16'sd8192);
    send_request(16'sd11520, 16'sd1000, 16'sd2000, 16'sd3000);
    send_request(-16'sd11520, 16'sd1000, -16'sd2000, 16'sd3000);
    send_request(16'sd23040, 16'sd0, 16'sd0, 16'sd8192);
    send_request(-16'sd23040, 16'sd8192, 16'sd0, 16'sd0);
    send_request(16'sd2880, 16'sd0, 16'sd0, 16'sd0);
    send_request(-16'sd17000, 16'sd0, 16'sd0, 16'sd0);
    send_request(16'sd3000, 16'sd32767, 16'sd32767, 16'sd32767);
    send_request(16'sd3000, -16'sd32768, -16'sd32768, -16'sd32768);
    send_request(-16'sd9000, 16'sd32767, -16'sd32768, 16'sd1);
    send_request(16'sd4000, 16'sd1, 16'sd0, 16'sd0);
    send_request(16'sd4000, 16'sd8191, 16'sd0, 16'sd0);
    send_request(16'sd4000, 16'sd8193, 16'sd0, 16'sd0);
    send_request(16'sd7000, 16'sd8192, 16'sd20, -16'sd20);
    send_request(16'sd12345, 16'sd5792, 16'sd5792, 16'sd0);
    wait_drained;

    send_idle = 36;
    recv_idle = 78;
    repeat (300) send_random;
    wait_drained;   // hold off until every matrix is back
    send_idle = 78;
    recv_idle = 36;
    repeat (300) send_random;
    send_idle = 0;
    recv_idle = 0;
    repeat (300) send_random;
    wait_drained;
    repeat (100) @(posedge clk_i);
    if (sb.fails == 0 && sb.pending_matrices.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin
    #5ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule

>>> axis_angle_rotation_matrix_top.f
design/aarm_pkg.sv
design/aarm_cell.sv
design/aarm_sqrt.sv
design/axis_angle_rotation_matrix_top.sv
test/axis_angle_rotation_matrix_top_tb.sv
